/* rtl/nmea_pe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA position extractor package
// Shared constants, the control bundle from the sentence parser to the
// coordinate accumulator, and small constant tables.
// ----------------------------------------------------------------------------
package nmea_pe_pkg;

	localparam int FRAC_DIGITS_DEF = 4;
	localparam int INT_DIGITS_DEF  = 5;

	localparam int CHAR_W    = 8;
	localparam int COORD_W   = 30;
	localparam int FIELD_W   = 4;
	localparam int HDR_POS_W = 3;
	localparam int DIGIT_W   = 4;

	localparam logic [HDR_POS_W-1:0] HDR_LEN     = 3'd5;
	localparam logic [FIELD_W-1:0]   FIELD_LIMIT = 4'd15;
	localparam logic [FIELD_W-1:0]   FIELD_STATUS = 4'd2;
	localparam logic [FIELD_W-1:0]   FIELD_LAT_GGA = 4'd2;
	localparam logic [FIELD_W-1:0]   FIELD_LAT_RMC = 4'd3;
	localparam logic [FIELD_W-1:0]   FIELD_LON_OFFSET = 4'd2;

	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

	localparam logic [COORD_W-1:0] OUT_LIMIT = 30'd999999999;

	// Per-byte instructions for the coordinate accumulator.
	typedef struct packed {
		logic                 clear;     // sentence boundary
		logic                 field_end; // comma
		logic                 dot;       // decimal point in a coordinate field
		logic                 dig_lat;   // digit for the latitude
		logic                 dig_lon;   // digit for the longitude
		logic [DIGIT_W-1:0]   digit;
	} coord_ctrl_t;

	function automatic logic [CHAR_W-1:0] gga_char(input logic [HDR_POS_W-1:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx)
			3'd0: ch = 8'h47; // G
			3'd1: ch = 8'h50; // P
			3'd2: ch = 8'h47; // G
			3'd3: ch = 8'h47; // G
			3'd4: ch = 8'h41; // A
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [CHAR_W-1:0] rmc_char(input logic [HDR_POS_W-1:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx)
			3'd0: ch = 8'h47; // G
			3'd1: ch = 8'h50; // P
			3'd2: ch = 8'h52; // R
			3'd3: ch = 8'h4D; // M
			3'd4: ch = 8'h43; // C
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Powers of ten used as digit weights (up to six fraction digits).
	function automatic logic [19:0] pow10(input logic [2:0] k);
		logic [19:0] w;
		case (k)
			3'd0: w = 20'd1;
			3'd1: w = 20'd10;
			3'd2: w = 20'd100;
			3'd3: w = 20'd1000;
			3'd4: w = 20'd10000;
			3'd5: w = 20'd100000;
			3'd6: w = 20'd1000000;
			default: w = 20'd0;
		endcase
		return w;
	endfunction

	// Saturation bound, evaluated at elaboration.
	function automatic logic [COORD_W-1:0] sat_limit(input int int_digits, input int frac_digits);
		longint p;
		p = 1;
		for (int i = 0; i < int_digits + frac_digits; i++) begin
			p = p * 10;
		end
		p = p - 1;
		if (p > longint'(OUT_LIMIT)) begin
			p = longint'(OUT_LIMIT);
		end
		return COORD_W'(p);
	endfunction

endpackage
`default_nettype wire

/* rtl/nmea_position_extractor_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA position extractor unit
// Pulls latitude and longitude out of GGA and RMC sentences arriving as a
// byte stream and emits one fixed-point position per qualifying sentence.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// s_*       in         one ASCII character per transaction (tdata[7:0])
// m_*       out        one position per sentence: tuser = kind,
//                      tdata = latitude [29:0], longitude [59:30]
//
// Every byte is taken into an input register that feeds a single pass of
// parser and digit accumulator logic, whose result lands in the output
// register. The sustained rate is one byte per cycle as long as results are
// drained. While a result waits in the output register and is not being
// drained, the byte in the input register is held and no new byte is
// accepted; the input resumes in the cycle the result is taken. Reset clears
// all sentence state at once; no start-up sweep is needed.
// ----------------------------------------------------------------------------
module nmea_position_extractor_unit #(
	parameter int FRAC_DIGITS = nmea_pe_pkg::FRAC_DIGITS_DEF,
	parameter int INT_DIGITS  = nmea_pe_pkg::INT_DIGITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [63:0]     m_tdata,   // [29:0] latitude_scaled, [59:30] longitude_scaled
	output logic            m_tuser    // [0] sentence_kind (0 GGA, 1 RMC)
);
	import nmea_pe_pkg::*;

	// Input stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] byte_s1;
	logic              adv;

	// Result register.
	logic               m_valid_q;
	logic               kind_q;
	logic [COORD_W-1:0] lat_q, lon_q;

	coord_ctrl_t        ctrl;
	logic               emit, is_rmc;
	logic [COORD_W-1:0] lat, lon;

	// The byte in the input stage is processed whenever the result register
	// can take whatever it might produce.
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	nmea_pe_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.char_in (byte_s1),
		.ctrl    (ctrl),
		.emit    (emit),
		.is_rmc  (is_rmc)
	);

	nmea_pe_coord_acc #(
		.FRAC_DIGITS (FRAC_DIGITS),
		.INT_DIGITS  (INT_DIGITS)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ctrl   (ctrl),
		.lat    (lat),
		.lon    (lon)
	);

	// A result is captured at the comma that closes the longitude field; the
	// accumulators are unchanged by a comma, so their current values are final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q <= is_rmc;
			lat_q  <= lat;
			lon_q  <= lon;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {4'b0000, lon_q, lat_q};

endmodule
`default_nettype wire

/* rtl/nmea_pe_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA position extractor: sentence parser
// Tracks the header match, the field count and the RMC status, and decides
// per byte what the accumulator does and whether a result is due.
// ----------------------------------------------------------------------------
module nmea_pe_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [nmea_pe_pkg::CHAR_W-1:0] char_in,
	output nmea_pe_pkg::coord_ctrl_t           ctrl,
	output logic                               emit,
	output logic                               is_rmc
);
	import nmea_pe_pkg::*;

	logic [HDR_POS_W-1:0] hdr_pos_q, hdr_pos_n;
	logic                 gga_q, gga_n;
	logic                 rmc_q, rmc_n;
	logic [FIELD_W-1:0]   field_q;
	logic                 status_q;
	logic                 done_q;

	logic                 is_ws, is_comma, is_digit, hdr_upd, hdr_ok, in_coord;
	logic [FIELD_W-1:0]   lat_f, lon_f;

	always_comb begin
		is_ws    = (char_in == CHAR_SPACE) || (char_in >= CHAR_TAB && char_in <= CHAR_CR);
		is_comma = (char_in == CHAR_COMMA);
		is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);

		hdr_upd   = (field_q == '0) && (hdr_pos_q < HDR_LEN);
		gga_n     = gga_q && (!hdr_upd || (char_in == gga_char(hdr_pos_q)));
		rmc_n     = rmc_q && (!hdr_upd || (char_in == rmc_char(hdr_pos_q)));
		hdr_pos_n = hdr_upd ? hdr_pos_q + 3'd1 : hdr_pos_q;

		hdr_ok = (hdr_pos_n == HDR_LEN) && (gga_n || rmc_n);
		is_rmc = rmc_n && !gga_n;
		lat_f  = is_rmc ? FIELD_LAT_RMC : FIELD_LAT_GGA;
		lon_f  = lat_f + FIELD_LON_OFFSET;

		emit = !is_ws && is_comma && hdr_ok && !done_q && (field_q == lon_f)
			&& (!is_rmc || status_q);

		in_coord = !is_ws && !is_comma && hdr_ok && (field_q != '0)
			&& ((field_q == lat_f) || (field_q == lon_f));

		ctrl.clear     = is_ws;
		ctrl.field_end = !is_ws && is_comma;
		ctrl.dot       = in_coord && (char_in == CHAR_DOT);
		ctrl.dig_lat   = in_coord && is_digit && (field_q == lat_f);
		ctrl.dig_lon   = in_coord && is_digit && (field_q == lon_f);
		ctrl.digit     = DIGIT_W'(char_in - CHAR_ZERO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= '0;
			gga_q     <= 1'b1;
			rmc_q     <= 1'b1;
			field_q   <= '0;
			status_q  <= 1'b0;
			done_q    <= 1'b0;
		end else if (en) begin
			if (is_ws) begin
				hdr_pos_q <= '0;
				gga_q     <= 1'b1;
				rmc_q     <= 1'b1;
				field_q   <= '0;
				status_q  <= 1'b0;
				done_q    <= 1'b0;
			end else begin
				hdr_pos_q <= hdr_pos_n;
				gga_q     <= gga_n;
				rmc_q     <= rmc_n;
				if (is_comma) begin
					if (field_q < FIELD_LIMIT) begin
						field_q <= field_q + 4'd1;
					end
					if (emit) begin
						done_q <= 1'b1;
					end
				end else if (hdr_ok && is_rmc && field_q == FIELD_STATUS && char_in == CHAR_A) begin
					status_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/nmea_pe_coord_acc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA position extractor: coordinate accumulator
// Builds latitude and longitude as decimal fixed point, one digit per byte,
// with truncation of surplus fraction digits and saturation.
// ----------------------------------------------------------------------------
module nmea_pe_coord_acc #(
	parameter int FRAC_DIGITS = nmea_pe_pkg::FRAC_DIGITS_DEF,
	parameter int INT_DIGITS  = nmea_pe_pkg::INT_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire nmea_pe_pkg::coord_ctrl_t        ctrl,
	output logic [nmea_pe_pkg::COORD_W-1:0]      lat,
	output logic [nmea_pe_pkg::COORD_W-1:0]      lon
);
	import nmea_pe_pkg::*;

	localparam int CNT_W = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
	localparam int SUM_W = COORD_W + 5;
	localparam logic [COORD_W-1:0] SAT_LIMIT = sat_limit(INT_DIGITS, FRAC_DIGITS);
	localparam logic [2:0]         FRAC_W3   = 3'(FRAC_DIGITS);
	localparam logic [CNT_W-1:0]   FRAC_CNT  = CNT_W'(FRAC_DIGITS);

	logic [COORD_W-1:0] lat_q, lon_q;
	logic               frac_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [COORD_W-1:0] acc, acc_n;
	logic [SUM_W-1:0]   acc_w, sum, prod;
	logic [19:0]        weight;
	logic               frac_take;

	always_comb begin
		acc       = ctrl.dig_lat ? lat_q : lon_q;
		acc_w     = SUM_W'(acc);
		frac_take = frac_q && (cnt_q < FRAC_CNT);
		if (!frac_q) begin
			weight = pow10(FRAC_W3);
		end else begin
			weight = pow10(FRAC_W3 - 3'd1 - 3'(cnt_q));
		end
		prod = SUM_W'(ctrl.digit) * SUM_W'(weight);
		if (!frac_q) begin
			sum = (acc_w << 3) + (acc_w << 1) + prod;
		end else if (frac_take) begin
			sum = acc_w + prod;
		end else begin
			sum = acc_w;
		end
		acc_n = (sum > SUM_W'(SAT_LIMIT)) ? SAT_LIMIT : sum[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q  <= '0;
			lon_q  <= '0;
			frac_q <= 1'b0;
			cnt_q  <= '0;
		end else if (en) begin
			if (ctrl.clear) begin
				lat_q  <= '0;
				lon_q  <= '0;
				frac_q <= 1'b0;
				cnt_q  <= '0;
			end else if (ctrl.field_end) begin
				frac_q <= 1'b0;
				cnt_q  <= '0;
			end else if (ctrl.dot) begin
				frac_q <= 1'b1;
			end else if (ctrl.dig_lat || ctrl.dig_lon) begin
				if (ctrl.dig_lat) begin
					lat_q <= acc_n;
				end else begin
					lon_q <= acc_n;
				end
				if (frac_take) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign lat = lat_q;
	assign lon = lon_q;

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the NMEA position extractor unit
// Streams GGA and RMC sentences, broken sentences and noise one character per
// transaction, predicts every position in a scoreboard and checks each result.
// ----------------------------------------------------------------------------
module tb;
	import nmea_pe_pkg::*;

	localparam int FRAC_DIGITS = 4;
	localparam int INT_DIGITS  = 5;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_REPORTS = 20;

	localparam string HDR_GGA = "GPGGA";
	localparam string HDR_RMC = "GPRMC";

	localparam logic KIND_GGA = 1'b0;
	localparam logic KIND_RMC = 1'b1;

	typedef logic [CHAR_W-1:0] char_t;

	// Ways in which a generated sentence may be spoilt.
	typedef enum int {
		FLAW_NONE,
		FLAW_HEADER,
		FLAW_TRUNC,
		FLAW_STATUS,
		FLAW_NO_END
	} flaw_e;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] lon;
	} position_t;

	// Tracks the sentence state of the unit and holds the positions still due.
	class nmea_position_board;
		logic [HDR_POS_W-1:0] hdr_pos;
		bit                   gga_ok;
		bit                   rmc_ok;
		logic [FIELD_W-1:0]   field;
		bit                   status_ok;
		logic [COORD_W-1:0]   lat_acc;
		logic [COORD_W-1:0]   lon_acc;
		bit                   in_frac;
		int unsigned          frac_cnt;
		bit                   done;
		longint               sat_max;
		position_t            positions_due[$];
		int                   noted, predicted, checked, errors;
		int                   gga_seen, rmc_seen, saturated;

		function new();
			sat_max = ten_to(INT_DIGITS + FRAC_DIGITS) - 1;
			if (sat_max > longint'(OUT_LIMIT)) begin
				sat_max = longint'(OUT_LIMIT);
			end
			clear_sentence();
		endfunction

		function longint ten_to(int k);
			longint p;
			p = 1;
			repeat (k) p = p * 10;
			return p;
		endfunction

		function void clear_sentence();
			hdr_pos   = '0;
			gga_ok    = 1'b1;
			rmc_ok    = 1'b1;
			field     = '0;
			status_ok = 1'b0;
			lat_acc   = '0;
			lon_acc   = '0;
			in_frac   = 1'b0;
			frac_cnt  = 0;
			done      = 1'b0;
		endfunction

		// Integer digits shift the value up; fraction digits beyond the
		// configured count are dropped. The value is clamped after each digit.
		function logic [COORD_W-1:0] push_digit(logic [COORD_W-1:0] acc, int unsigned d);
			longint v;
			v = acc;
			if (!in_frac) begin
				v = v * 10 + d * ten_to(FRAC_DIGITS);
			end else if (frac_cnt < FRAC_DIGITS) begin
				v = v + d * ten_to(FRAC_DIGITS - 1 - frac_cnt);
				frac_cnt++;
			end
			if (v > sat_max) begin
				v = sat_max;
			end
			return v[COORD_W-1:0];
		endfunction

		function int pending();
			return positions_due.size();
		endfunction

		// Called for every character the unit accepts.
		function void take_char(char_t c);
			bit                 hdr_good;
			bit                 rmc_kind;
			logic [FIELD_W-1:0] lat_f;
			logic [FIELD_W-1:0] lon_f;
			position_t          p;
			noted++;
			if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
				clear_sentence();
				return;
			end
			if (field == 0 && hdr_pos < HDR_LEN) begin
				if (c != char_t'(HDR_GGA[hdr_pos])) gga_ok = 1'b0;
				if (c != char_t'(HDR_RMC[hdr_pos])) rmc_ok = 1'b0;
				hdr_pos++;
			end
			hdr_good = (hdr_pos == HDR_LEN) && (gga_ok || rmc_ok);
			rmc_kind = rmc_ok && !gga_ok;
			lat_f    = rmc_kind ? FIELD_LAT_RMC : FIELD_LAT_GGA;
			lon_f    = lat_f + FIELD_LON_OFFSET;
			if (c == CHAR_COMMA) begin
				if (hdr_good && !done && field == lon_f && (!rmc_kind || status_ok)) begin
					p.kind = rmc_kind ? KIND_RMC : KIND_GGA;
					p.lat  = lat_acc;
					p.lon  = lon_acc;
					positions_due.push_back(p);
					predicted++;
					done = 1'b1;
				end
				if (field < FIELD_LIMIT) field++;
				in_frac  = 1'b0;
				frac_cnt = 0;
				return;
			end
			if (!hdr_good || field == 0) return;
			if (rmc_kind && field == FIELD_STATUS && c == CHAR_A) status_ok = 1'b1;
			if (field == lat_f || field == lon_f) begin
				if (c == CHAR_DOT) begin
					in_frac = 1'b1;
				end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					if (field == lat_f) lat_acc = push_digit(lat_acc, c - CHAR_ZERO);
					else lon_acc = push_digit(lon_acc, c - CHAR_ZERO);
				end
			end
		endfunction

		function void report_mismatch(string what, logic [COORD_W-1:0] want,
				logic [COORD_W-1:0] got);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			end
		endfunction

		// Called for every position the unit hands out.
		function void check_position(logic kind, logic [COORD_W-1:0] lat,
				logic [COORD_W-1:0] lon);
			position_t want;
			checked++;
			if (positions_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: unexpected position, expected none, actual kind %0d lat %0d lon %0d",
						$time, kind, lat, lon);
				end
				return;
			end
			want = positions_due.pop_front();
			if (want.kind == KIND_RMC) rmc_seen++;
			else gga_seen++;
			if (want.lat == sat_max || want.lon == sat_max) saturated++;
			if (kind !== want.kind) report_mismatch("sentence kind", want.kind, kind);
			if (lat !== want.lat) report_mismatch("latitude", want.lat, lat);
			if (lon !== want.lon) report_mismatch("longitude", want.lon, lon);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [29:0] latitude_scaled, [59:30] longitude_scaled
	logic        m_tuser;   // [0] sentence_kind

	nmea_position_board board;
	char_t              text_q[$];
	bit                 calm;
	int                 still_cycles;
	int                 runs;
	bit                 drained;

	nmea_position_extractor_unit #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.INT_DIGITS (INT_DIGITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// In calm stretches neither side idles at all.
	function automatic int draw_wait();
		if (calm) return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic char_t junk_char();
		char_t c;
		do begin
			c = char_t'($urandom_range(0, 255));
		end while (c == CHAR_COMMA || c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
		return c;
	endfunction

	function automatic void put_text(string t);
		for (int i = 0; i < t.len(); i++) text_q.push_back(t[i]);
	endfunction

	function automatic void put_digits(int n);
		repeat (n) text_q.push_back(CHAR_ZERO + char_t'($urandom_range(0, 9)));
	endfunction

	function automatic void put_terminator();
		int k;
		k = $urandom_range(0, 5);
		text_q.push_back(k == 5 ? CHAR_SPACE : CHAR_TAB + char_t'(k));
	endfunction

	// A coordinate: mostly ordinary, sometimes empty, over-long (saturating),
	// with surplus fraction digits, a second point or a stray character.
	function automatic void put_coord();
		int style;
		style = $urandom_range(0, 19);
		if (style == 0) return;
		put_digits(style < 3 ? $urandom_range(6, 9) : $urandom_range(1, 5));
		if ($urandom_range(0, 9) != 0) begin
			text_q.push_back(CHAR_DOT);
			put_digits($urandom_range(0, 7));
		end
		if (style == 4) begin
			text_q.push_back(CHAR_DOT);
			put_digits($urandom_range(1, 3));
		end
		if (style == 5) begin
			text_q.push_back(junk_char());
			put_digits($urandom_range(1, 3));
		end
	endfunction

	function automatic void put_sentence(bit rmc, flaw_e flaw);
		string hdr;
		int    n;
		hdr = rmc ? HDR_RMC : HDR_GGA;
		put_text(hdr);
		if (flaw == FLAW_HEADER) begin
			n = text_q.size() - 5 + $urandom_range(0, 4);
			text_q[n] = ($urandom_range(0, 2) == 0) ? CHAR_COMMA : junk_char();
		end
		if ($urandom_range(0, 7) == 0) text_q.push_back(junk_char());
		text_q.push_back(CHAR_COMMA);
		put_digits($urandom_range(0, 6));
		text_q.push_back(CHAR_COMMA);
		if (rmc) begin
			if (flaw == FLAW_STATUS) begin
				if ($urandom_range(0, 1) == 0) put_text("V");
			end else begin
				if ($urandom_range(0, 4) == 0) text_q.push_back(junk_char());
				text_q.push_back(CHAR_A);
			end
			text_q.push_back(CHAR_COMMA);
		end
		put_coord();
		text_q.push_back(CHAR_COMMA);
		put_text($urandom_range(0, 1) ? "N" : "S");
		text_q.push_back(CHAR_COMMA);
		put_coord();
		if (flaw == FLAW_TRUNC) begin
			put_terminator();
			return;
		end
		text_q.push_back(CHAR_COMMA);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 3);
		repeat (n) begin
			put_digits($urandom_range(0, 3));
			text_q.push_back(CHAR_COMMA);
		end
		if (flaw != FLAW_NO_END) put_terminator();
	endfunction

	function automatic void put_noise();
		repeat ($urandom_range(1, 16)) text_q.push_back(char_t'($urandom_range(0, 255)));
		put_terminator();
	endfunction

	// Offers one character and waits for its transaction to complete.
	task automatic send_char(input char_t c);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_char(c);
	endtask

	task automatic send_text();
		while (text_q.size() != 0) send_char(text_q.pop_front());
		runs++;
	endtask

	// Counts cycles without any transaction on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) still_cycles <= 0;
		else still_cycles <= still_cycles + 1;
	end

	initial begin
		wait (still_cycles >= STALL_LIMIT);
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: a random stall before each position, then take it.
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = draw_wait();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			board.check_position(m_tuser, m_tdata[29:0], m_tdata[59:30]);
		end
	end

	initial begin
		int    pick;
		board        = new();
		still_cycles = 0;
		runs         = 0;
		drained      = 1'b0;
		calm         = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		m_tready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sentences: empty fields, saturation and truncation, a bad
		// status, surplus header characters with a second point and a stray
		// character, a comma inside the header, a wrong header, extreme byte
		// values inside a field, and a field count that runs into its limit.
		put_text("GPGGA,,,,,");
		text_q.push_back(CHAR_CR);
		put_text("GPRMC,,A,1234567.8,,0.98765,");
		text_q.push_back(CHAR_SPACE);
		put_text("GPRMC,1,V,1,,2,");
		text_q.push_back(CHAR_TAB);
		put_text("GPGGAXY,,9.9.9,,x8,");
		text_q.push_back(CHAR_SPACE);
		put_text("GP,GA,,1,,2,");
		text_q.push_back(CHAR_SPACE);
		put_text("GPGGB,,1,,2,");
		text_q.push_back(CHAR_SPACE);
		put_text("GPGGA,,");
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		put_text("5,,");
		text_q.push_back(8'h80);
		put_text("7,,,,,,,,,,,,,,,,,,");
		text_q.push_back(CHAR_SPACE);
		put_text("GPGGA,,99999.9999,,00000.0000,");
		text_q.push_back(CHAR_SPACE);
		send_text();

		// Random part: mostly well-formed sentences, some spoilt, some noise.
		while (board.noted < 1900 || board.predicted < 60) begin
			calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) put_sentence($urandom_range(0, 1), FLAW_NONE);
			else if (pick < 88) put_sentence($urandom_range(0, 1), flaw_e'($urandom_range(1, 4)));
			else put_noise();
			send_text();
			if (!drained && board.noted >= 950) begin
				// Hold the input back until every position due has come out.
				drained = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (board.pending() != 0);
			end
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d characters in %0d sentences or noise runs.", board.noted, runs);
		$display("Checked %0d positions: %0d GGA, %0d RMC, %0d saturated; %0d mismatches.",
			board.checked, board.gga_seen, board.rmc_seen, board.saturated, board.errors);
		if (board.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/nmea_pe_pkg.sv
rtl/nmea_pe_parser.sv
rtl/nmea_pe_coord_acc.sv
rtl/nmea_position_extractor_unit.sv
bench/tb.sv
